/* hw/rtl/pfc_pkg.sv */
// Shared types for the pattern frequency counter table.
`default_nettype none

package pfc_pkg;

    typedef enum logic {
        PFC_OP_ADD   = 1'b0,
        PFC_OP_QUERY = 1'b1
    } pfc_op_t;

    typedef struct packed {
        pfc_op_t     opcode;
        logic [63:0] pattern;
        logic [31:0] amount;
    } pfc_request_t;

    typedef struct packed {
        logic [31:0] count;
        logic        found;
        logic        table_full;
        logic        saturated;
    } pfc_result_t;

    // Outcome of one key lookup, passed from the key store to the count stage.
    typedef struct packed {
        logic found;
        logic alloc;
        logic full;
    } pfc_lookup_t;

endpackage

`default_nettype wire

/* hw/rtl/pfc_key_cam.sv */
// Key store: parallel key compare, valid bits and allocation of new entries.
`default_nettype none

module pfc_key_cam #(
    parameter int ENTRIES = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         lookup_en,
    input  wire pfc_pkg::pfc_op_t             opcode,
    input  wire logic [63:0]                  pattern,
    output pfc_pkg::pfc_lookup_t              lookup,
    output logic [$clog2(ENTRIES)-1:0]        idx
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int USED_W = $clog2(ENTRIES + 1);

    logic [63:0]       key_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;

    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              full;
    logic              alloc;

    // Keys in the table are distinct, so at most one entry matches: OR the indices.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && key_reg[i] == pattern)
            begin
                hit     = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // Entries are never freed, so the lowest free entry is the fill count.
    assign full      = (used_reg == USED_W'(ENTRIES));
    assign alloc     = lookup_en && opcode == pfc_pkg::PFC_OP_ADD && !hit && !full;
    assign used_next = used_reg + USED_W'(1);

    assign lookup.found = lookup_en && hit;
    assign lookup.alloc = alloc;
    assign lookup.full  = lookup_en && opcode == pfc_pkg::PFC_OP_ADD && !hit && full;
    assign idx          = hit ? hit_idx : used_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
        end
        else if (alloc)
        begin
            valid_reg[used_reg[IDX_W-1:0]] <= 1'b1;
            used_reg                       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            key_reg[used_reg[IDX_W-1:0]] <= pattern;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pfc_count_stage.sv */
// Count store and saturating update, with forwarding between back-to-back requests.
`default_nettype none

module pfc_count_stage #(
    parameter int ENTRIES     = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         a_valid,
    input  wire pfc_pkg::pfc_op_t             a_opcode,
    input  wire logic [31:0]                  a_amount,
    input  wire pfc_pkg::pfc_lookup_t         a_lookup,
    input  wire logic [$clog2(ENTRIES)-1:0]   a_idx,
    output logic                              res_valid,
    output pfc_pkg::pfc_result_t              res
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SUM_W = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
    localparam int EXT_W = COUNT_WIDTH + 32;

    logic [COUNT_WIDTH-1:0] count_mem [ENTRIES];

    logic                   b_valid_reg;
    pfc_pkg::pfc_lookup_t   b_lookup_reg;
    pfc_pkg::pfc_op_t       b_opcode_reg;
    logic [31:0]            b_amount_reg;
    logic [IDX_W-1:0]       b_idx_reg;
    logic [COUNT_WIDTH-1:0] rd_reg;
    logic                   fwd_sel_reg;
    logic [COUNT_WIDTH-1:0] fwd_val_reg;
    logic                   fwd_sel_next;

    logic                   is_add;
    logic                   live;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] cur;
    logic [SUM_W-1:0]       sum;
    logic                   clip;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [COUNT_WIDTH-1:0] out_count;
    logic [EXT_W-1:0]       out_ext;

    assign is_add = (b_opcode_reg == pfc_pkg::PFC_OP_ADD);
    assign live   = b_lookup_reg.found || b_lookup_reg.alloc;
    assign wr_en  = b_valid_reg && is_add && live;

    // A fresh entry starts from zero; a hit takes the stored or forwarded count.
    assign cur = !b_lookup_reg.found ? '0 : (fwd_sel_reg ? fwd_val_reg : rd_reg);

    assign sum       = SUM_W'(cur) + SUM_W'(b_amount_reg);
    assign clip      = |sum[SUM_W-1:COUNT_WIDTH];
    assign new_count = clip ? '1 : sum[COUNT_WIDTH-1:0];
    assign out_count = !live ? '0 : (is_add ? new_count : cur);
    assign out_ext   = EXT_W'(out_count);

    assign res_valid      = b_valid_reg;
    assign res.count      = out_ext[31:0];
    assign res.found      = b_lookup_reg.found;
    assign res.table_full = b_lookup_reg.full;
    assign res.saturated  = is_add && live && clip;

    // The memory read below misses a write landing in the same cycle: forward it.
    assign fwd_sel_next = wr_en && (b_idx_reg == a_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        b_lookup_reg <= a_lookup;
        b_opcode_reg <= a_opcode;
        b_amount_reg <= a_amount;
        b_idx_reg    <= a_idx;
        rd_reg       <= count_mem[a_idx];
        fwd_sel_reg  <= fwd_sel_next;
        fwd_val_reg  <= new_count;
        if (wr_en)
        begin
            count_mem[b_idx_reg] <= new_count;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pattern_frequency_counter_table.sv */
// Top level of the pattern frequency counter table.
//
// Keeps up to ENTRIES distinct 64-bit patterns with a COUNT_WIDTH-bit hit
// count each. A request is taken at every clock edge where start is high;
// busy never rises, so one request per cycle is sustained. Each request
// gives exactly one result, in request order. done rises once the request
// has passed the request, count read and result registers; done and the
// result are valid together for a single cycle only.
// There is no way to hold a result: the receiver must take it in
// that cycle. The latency is set by three registers: the request register
// (whose cycle carries the parallel key compare over all entries), the
// count memory read register (whose cycle carries the saturating add and
// the write-back), and the result register. A request that updates the
// same pattern as the one just ahead of it sees that update through a
// forwarding path, so back-to-back hits on one pattern count correctly.
// New patterns take entries in order and entries are only released by
// reset; reset clears the valid bits and fill count at once, so no
// clearing pass is needed and the block is ready as soon as reset ends.
// count carries the low 32 bits of the stored count.
`default_nettype none

module pattern_frequency_counter_table #(
    parameter int ENTRIES     = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire pfc_pkg::pfc_request_t request,
    output logic                       done,
    output pfc_pkg::pfc_result_t       result
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic                  req_valid_reg;
    pfc_pkg::pfc_request_t req_reg;

    pfc_pkg::pfc_lookup_t  lookup;
    logic [IDX_W-1:0]      lookup_idx;

    logic                  res_valid;
    pfc_pkg::pfc_result_t  res;

    logic                  done_reg;
    pfc_pkg::pfc_result_t  result_reg;

    // Every stage advances each cycle; nothing ever holds a request back.
    assign busy = 1'b0;

    // Capture the request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= request;
    end

    // Look the pattern up and allocate an entry for a new one.
    pfc_key_cam #(
        .ENTRIES (ENTRIES)
    ) u_key_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup_en (req_valid_reg),
        .opcode    (req_reg.opcode),
        .pattern   (req_reg.pattern),
        .lookup    (lookup),
        .idx       (lookup_idx)
    );

    // Read, update and write back the count.
    pfc_count_stage #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_valid   (req_valid_reg),
        .a_opcode  (req_reg.opcode),
        .a_amount  (req_reg.amount),
        .a_lookup  (lookup),
        .a_idx     (lookup_idx),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the result for its one cycle on the ports.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every request taken produces its result, with done high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result missing three cycles after request");

    // No result without a matching earlier request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(done)) |-> $past(start, 3))
        else $error("result without a matching request");

    // A dropped pattern is never reported as found, counted or clipped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |->
            (!result.found && !result.saturated && result.count == 32'd0))
        else $error("dropped request reports a count");

endmodule

`default_nettype wire

/* tb/pfc_checker.sv */
// Checker for the pattern frequency counter table: predicts each result and compares it.
module pfc_checker
    import pfc_pkg::*;
#(
    parameter int ENTRIES     = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire pfc_request_t request,
    input  wire logic         done,
    input  wire pfc_result_t  result,
    output int unsigned       fail_count,
    output int unsigned       pending,
    output int unsigned       requests_seen,
    output int unsigned       adds_seen,
    output int unsigned       hits_seen,
    output int unsigned       drops_seen,
    output int unsigned       clips_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [64:0] COUNT_LIMIT = (65'd1 << COUNT_WIDTH) - 65'd1;

    logic [63:0]            key_mem   [ENTRIES];
    logic [COUNT_WIDTH-1:0] count_mem [ENTRIES];
    bit                     valid_mem [ENTRIES];
    pfc_result_t            expected_results [$];
    int unsigned            mismatches;
    int unsigned            n_requests, n_adds, n_hits, n_drops, n_clips;

    // Apply one request to the shadow table and return the result it must give.
    function automatic pfc_result_t tally_request(input pfc_request_t req);
        pfc_result_t res;
        int          hit_idx;
        int          free_idx;
        logic [64:0] total;
        res      = '0;
        hit_idx  = -1;
        free_idx = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_mem[i])
            begin
                if (hit_idx < 0 && key_mem[i] == req.pattern)
                    hit_idx = i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        if (hit_idx >= 0)
        begin
            res.found = 1'b1;
            if (req.opcode == PFC_OP_ADD)
            begin
                total = 65'(count_mem[hit_idx]) + 65'(req.amount);
                if (total > COUNT_LIMIT)
                begin
                    total         = COUNT_LIMIT;
                    res.saturated = 1'b1;
                end
                count_mem[hit_idx] = total[COUNT_WIDTH-1:0];
            end
            res.count = 32'(count_mem[hit_idx]);
        end
        else if (req.opcode == PFC_OP_ADD)
        begin
            if (free_idx >= 0)
            begin
                total = 65'(req.amount);
                if (total > COUNT_LIMIT)
                begin
                    total         = COUNT_LIMIT;
                    res.saturated = 1'b1;
                end
                valid_mem[free_idx] = 1'b1;
                key_mem[free_idx]   = req.pattern;
                count_mem[free_idx] = total[COUNT_WIDTH-1:0];
                res.count           = 32'(count_mem[free_idx]);
            end
            else
                res.table_full = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        pfc_result_t want;
        if (!rst_n)
        begin
            foreach (valid_mem[i])
                valid_mem[i] = 1'b0;
            expected_results.delete();
            mismatches = 0;
            n_requests = 0;
            n_adds     = 0;
            n_hits     = 0;
            n_drops    = 0;
            n_clips    = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("pfc_checker: %0t: result with none outstanding", $time);
                        $display("pfc_checker: got count=%h found=%b full=%b sat=%b",
                                 result.count, result.found, result.table_full,
                                 result.saturated);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.count !== want.count || result.found !== want.found ||
                        result.table_full !== want.table_full ||
                        result.saturated !== want.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("pfc_checker: %0t: expected count=%h found=%b full=%b sat=%b",
                                     $time, want.count, want.found, want.table_full,
                                     want.saturated);
                            $display("pfc_checker: %0t: got      count=%h found=%b full=%b sat=%b",
                                     $time, result.count, result.found,
                                     result.table_full, result.saturated);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                want = tally_request(request);
                expected_results.push_back(want);
                n_requests++;
                if (request.opcode == PFC_OP_ADD)
                    n_adds++;
                if (want.found)
                    n_hits++;
                if (want.table_full)
                    n_drops++;
                if (want.saturated)
                    n_clips++;
            end
        end
        fail_count    <= mismatches;
        pending       <= expected_results.size();
        requests_seen <= n_requests;
        adds_seen     <= n_adds;
        hits_seen     <= n_hits;
        drops_seen    <= n_drops;
        clips_seen    <= n_clips;
    end

endmodule

/* tb/tb_top.sv */
// Top of the pattern frequency counter table testbench: clock, reset, requests and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int COUNT_WIDTH  = 32;
    // Slightly more keys than entries, so the table fills and later new keys are dropped.
    localparam int POOL_SIZE    = 72;
    localparam int RANDOM_ITEMS = 500;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic         done;
    pfc_request_t request;
    pfc_result_t  result;

    int unsigned  fail_count, pending;
    int unsigned  requests_seen, adds_seen, hits_seen, drops_seen, clips_seen;

    logic [63:0]  key_pool [POOL_SIZE];

    pattern_frequency_counter_table #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // The checker sits beside the block and sees exactly what crosses its ports.
    pfc_checker #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .adds_seen     (adds_seen),
        .hits_seen     (hits_seen),
        .drops_seen    (drops_seen),
        .clips_seen    (clips_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs or never returns a result.
    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic pfc_request_t make_req(input pfc_op_t op, input logic [63:0] key,
                                              input logic [31:0] amt);
        pfc_request_t req;
        req.opcode  = op;
        req.pattern = key;
        req.amount  = amt;
        return req;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Present one request, hold it until taken, then idle with start low for the gap, if any.
    // While idle the request bus carries junk, which the block must ignore.
    task automatic issue(input pfc_request_t req, input int unsigned gap);
        request <= req;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start   <= 1'b0;
            request <= make_req(pfc_op_t'($urandom_range(0, 1)), rand_key(), $urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [63:0] key;
        logic [31:0] amt;
        int unsigned gap;
        int unsigned pick;
        int unsigned waited;
        bit          calm;

        // Drive every input to a known value before anything else happens.
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            // Some keys differ from their neighbour in a single bit, to stress the compare.
            if (i > 0 && $urandom_range(0, 7) == 0)
                key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
            else
                key_pool[i] = rand_key();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: mostly back to back, so the forwarding path is hit.
        // Query on an empty table.
        issue(make_req(PFC_OP_QUERY, 64'd0, 32'hFFFF_FFFF), 0);
        // New pattern with amount zero still takes an entry.
        issue(make_req(PFC_OP_ADD, 64'd0, 32'd0), 0);
        issue(make_req(PFC_OP_QUERY, 64'd0, 32'd0), 1);
        // Largest amount on a new pattern, then push it over the top.
        issue(make_req(PFC_OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF), 0);
        issue(make_req(PFC_OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1), 0);
        issue(make_req(PFC_OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0), 0);
        issue(make_req(PFC_OP_ADD, 64'd0, 32'd1), 0);
        // Back-to-back adds on one new pattern, the last one clipping.
        issue(make_req(PFC_OP_ADD, 64'h5555_5555_5555_5555, 32'd7), 0);
        issue(make_req(PFC_OP_ADD, 64'h5555_5555_5555_5555, 32'd9), 0);
        issue(make_req(PFC_OP_ADD, 64'h5555_5555_5555_5555, 32'hFFFF_FFF0), 0);
        issue(make_req(PFC_OP_QUERY, 64'h5555_5555_5555_5555, 32'd3), 2);
        // Sum landing exactly on the maximum must not clip; a zero add then keeps it.
        issue(make_req(PFC_OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000), 0);
        issue(make_req(PFC_OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'h7FFF_FFFF), 0);
        issue(make_req(PFC_OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0), 0);
        // Key one bit away from a stored one is a different pattern.
        issue(make_req(PFC_OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAB, 32'd0), 0);
        issue(make_req(PFC_OP_QUERY, rand_key(), $urandom), 0);
        // Add then query the same key on consecutive cycles.
        issue(make_req(PFC_OP_ADD, 64'h8000_0000_0000_0001, 32'd1), 0);
        issue(make_req(PFC_OP_QUERY, 64'h8000_0000_0000_0001, 32'd0), 3);

        // Random part: pool keys make repeat hits, fresh keys fill the table and then
        // get dropped once it is full. Idle stretches alternate with calm bursts.
        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);

            pick = $urandom_range(0, 99);
            if (pick < 8)
                amt = 32'd0;
            else if (pick < 60)
                amt = (pick < 40) ? 32'd1 : 32'($urandom_range(2, 15));
            else if (pick < 88)
                amt = $urandom;
            else
                amt = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));

            pick = $urandom_range(0, 99);
            key  = (pick % 10 == 0) ? rand_key() : key_pool[$urandom_range(0, POOL_SIZE - 1)];

            if (calm)
                gap = 0;
            else
            begin
                gap = $urandom_range(0, 99);
                if (gap < 65)
                    gap = 0;
                else if (gap < 95)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(10, 40);
            end

            // Queries carry junk in amount, since it must be ignored.
            if (pick < 62)
                issue(make_req(PFC_OP_ADD, key, amt), gap);
            else
                issue(make_req(PFC_OP_QUERY, key, $urandom), gap);
        end
        start <= 1'b0;

        // Drain: wait for outstanding results, bounded, then allow for the latency.
        waited = 0;
        while (pending != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);

        $display("tb_top: %0d requests taken, %0d adds and %0d queries",
                 requests_seen, adds_seen, requests_seen - adds_seen);
        $display("tb_top: %0d hits, %0d dropped on a full table, %0d clipped counts",
                 hits_seen, drops_seen, clips_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_key_cam.sv
hw/rtl/pfc_count_stage.sv
hw/rtl/pattern_frequency_counter_table.sv
tb/pfc_checker.sv
tb/tb_top.sv
